@@ rtl/core/pspp_pkg.sv @@
// Shared types and constants of the PSI section payload parser.
// Holds table and record codes, the result record layout and the length helpers.
// No dependencies; compiled before every other file of the block.
package pspp_pkg;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_PAT  = 3'd1,
    KIND_PMT  = 3'd2,
    KIND_NIT  = 3'd3,
    KIND_SDT  = 3'd4
  } tbl_kind_t;

  typedef enum logic [2:0] {
    REC_NET_PID  = 3'd0,
    REC_PROG_PID = 3'd1,
    REC_PCR      = 3'd2,
    REC_STREAM   = 3'd3,
    REC_TS_ENTRY = 3'd4,
    REC_ONID     = 3'd5,
    REC_SERVICE  = 3'd6,
    REC_END      = 3'd7
  } rec_kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_PAT_LEN = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_TRUNCATED   = 2'd3
  } end_status_t;

  localparam logic [7:0] TID_PAT = 8'h00;
  localparam logic [7:0] TID_PMT = 8'h02;
  localparam logic [7:0] TID_NIT = 8'h40;
  localparam logic [7:0] TID_SDT = 8'h42;

  // Default depth of the result queue; two slots must always be free to take a beat.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    rec_kind_t   rec_kind;
    logic [15:0] id_a;
    logic [15:0] id_b;
    logic        eit_schedule;
    logic        eit_present_following;
    logic [2:0]  running_status;
    logic        scrambled;
    end_status_t status;
    logic        last;
  } rec_t;

  // Length of the fixed table header that precedes the entry loop.
  function automatic logic [2:0] hdr_len(tbl_kind_t kind);
    logic [2:0] len;
    case (kind)
      KIND_PMT: len = 3'd4;
      KIND_NIT: len = 3'd2;
      KIND_SDT: len = 3'd3;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  // Length of the fixed part of one loop entry.
  function automatic logic [2:0] ent_len(tbl_kind_t kind);
    logic [2:0] len;
    case (kind)
      KIND_PAT: len = 3'd4;
      KIND_NIT: len = 3'd6;
      default:  len = 3'd5;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/pspp_if.sv @@
// Channel interfaces of the PSI section payload parser: payload bytes in, records out.
// The result interface takes its record codes from pspp_pkg.
interface pspp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [7:0]  tbl_id;
  logic [15:0] table_ext;
  logic [11:0] payload_len;

  modport source (
    output valid, data_byte, first_byte, last_byte, tbl_id, table_ext, payload_len,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_byte, last_byte, tbl_id, table_ext, payload_len,
    output ready
  );
endinterface

interface pspp_out_if import pspp_pkg::*; ();
  logic        valid;
  logic        ready;
  rec_kind_t   rec_kind;
  logic [15:0] id_a;
  logic [15:0] id_b;
  logic        eit_schedule;
  logic        eit_present_following;
  logic [2:0]  running_status;
  logic        scrambled;
  end_status_t status;
  logic        last;

  modport source (
    output valid, rec_kind, id_a, id_b, eit_schedule, eit_present_following,
           running_status, scrambled, status, last,
    input  ready
  );
  modport sink (
    input  valid, rec_kind, id_a, id_b, eit_schedule, eit_present_following,
           running_status, scrambled, status, last,
    output ready
  );
endinterface

@@ rtl/core/psi_section_payload_parser.sv @@
// PSI section payload parser, top level (PAT, PMT, NIT and SDT).
// Depends on pspp_pkg for codes and record layout and on pspp_if.sv for the channels.
//
// Usage: the input channel in_ch carries one payload byte of a section per beat, with
// first_byte and last_byte marking the section boundaries and table_id, table_ext and
// payload_len sampled on every beat. The output channel out_ch carries one record per
// beat: entry records as each table entry completes, and a closing record (last high)
// with a status on the final byte of each section.
// Each record passes through the result queue before it leaves on out_ch; a beat that
// completes an entry and closes the section yields two records, the entry record first.
// Throughput: one byte per cycle while in_ch.ready is high. The parse state is updated
// directly at each accepted beat and the records go into a short result queue (QDEPTH
// entries), which parts the two sides. in_ch.ready is high while at least two queue slots
// are free, so a stalled receiver throttles the input only once fewer than two are free.
// Reset clears the parse state and empties the queue; no record is presented after reset
// until a byte has been accepted.
module psi_section_payload_parser import pspp_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  pspp_in_if.sink   in_ch,
  pspp_out_if.source out_ch
);

  localparam int CNT_W = $clog2(QDEPTH + 1);

  // Parse state, updated once per accepted beat.
  logic [11:0] byte_pos_r,    byte_pos_nxt;
  logic [11:0] skip_left_r,   skip_left_nxt;
  logic [2:0]  entry_phase_r, entry_phase_nxt;
  logic [39:0] held_r,        held_nxt;
  tbl_kind_t   kind_r,        kind_nxt;
  end_status_t err_r,         err_nxt;

  // Result queue: entry 0 is always the record on offer.
  rec_t             q_r [QDEPTH];
  rec_t             q_nxt [QDEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic accept;
  logic pop;
  logic ent_vld;
  logic end_vld;
  rec_t ent_rec;
  rec_t end_rec;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  // The parser itself. The state is first re-seeded when a section opens, then the byte is
  // walked through the header, the descriptor skip or the entry loop, and finally the
  // section is closed if this is its final byte.
  always_comb begin
    tbl_kind_t   kind_s;
    end_status_t err_s;
    logic [11:0] pos_s;
    logic [11:0] skip_s;
    logic [2:0]  phase_s;
    logic [39:0] held_s;
    logic [47:0] full;
    logic [11:0] hl;
    logic [2:0]  el;
    logic [2:0]  phase_inc;
    logic [12:0] nit_skip;
    logic [15:0] prog;
    end_status_t st;

    kind_s  = kind_r;
    err_s   = err_r;
    pos_s   = byte_pos_r;
    skip_s  = skip_left_r;
    phase_s = entry_phase_r;
    held_s  = held_r;

    if (in_ch.first_byte) begin
      case (in_ch.tbl_id)
        TID_PAT: kind_s = KIND_PAT;
        TID_PMT: kind_s = KIND_PMT;
        TID_NIT: kind_s = KIND_NIT;
        TID_SDT: kind_s = KIND_SDT;
        default: kind_s = KIND_NONE;
      endcase
      pos_s   = '0;
      skip_s  = '0;
      phase_s = '0;
      held_s  = '0;
      if (kind_s == KIND_NONE) begin
        err_s = ST_UNSUPPORTED;
      end else if (kind_s == KIND_PAT && in_ch.payload_len[1:0] != 2'b00) begin
        err_s = ST_BAD_PAT_LEN;
      end else begin
        err_s = ST_OK;
      end
    end

    // The held bytes of the current header or entry, with the new byte appended.
    full      = {held_s, in_ch.data_byte};
    hl        = {9'd0, hdr_len(kind_s)};
    el        = ent_len(kind_s);
    phase_inc = phase_s + 3'd1;
    nit_skip  = {1'b0, full[11:8], full[7:0]} + 13'd2;
    prog      = full[31:16];

    kind_nxt        = kind_s;
    err_nxt         = err_s;
    byte_pos_nxt    = pos_s;
    skip_left_nxt   = skip_s;
    entry_phase_nxt = phase_s;
    held_nxt        = held_s;
    ent_vld         = 1'b0;
    ent_rec         = '0;

    if (kind_s != KIND_NONE && err_s == ST_OK && pos_s < in_ch.payload_len) begin
      if (pos_s < hl) begin
        if (pos_s == hl - 12'd1) begin
          case (kind_s)
            KIND_PMT: begin
              ent_vld          = 1'b1;
              ent_rec.rec_kind = REC_PCR;
              ent_rec.id_a     = in_ch.table_ext;
              ent_rec.id_b     = {3'd0, full[28:24], full[23:16]};
              skip_left_nxt    = {full[11:8], full[7:0]};
            end
            KIND_NIT: begin
              // The network descriptors and the two byte loop length are skipped together.
              skip_left_nxt = nit_skip[12] ? 12'hFFF : nit_skip[11:0];
            end
            default: begin
              ent_vld          = 1'b1;
              ent_rec.rec_kind = REC_ONID;
              ent_rec.id_a     = in_ch.table_ext;
              ent_rec.id_b     = full[23:8];
            end
          endcase
          held_nxt = '0;
        end else begin
          held_nxt = full[39:0];
        end
      end else if (skip_s != 12'd0) begin
        skip_left_nxt = skip_s - 12'd1;
      end else if (phase_inc == el) begin
        ent_vld = 1'b1;
        case (kind_s)
          KIND_PAT: begin
            ent_rec.rec_kind = (prog == 16'd0) ? REC_NET_PID : REC_PROG_PID;
            ent_rec.id_a     = prog;
            ent_rec.id_b     = {3'd0, full[12:8], full[7:0]};
          end
          KIND_PMT: begin
            ent_rec.rec_kind = REC_STREAM;
            ent_rec.id_a     = {8'd0, full[39:32]};
            ent_rec.id_b     = {3'd0, full[28:24], full[23:16]};
            skip_left_nxt    = {full[11:8], full[7:0]};
          end
          KIND_NIT: begin
            ent_rec.rec_kind = REC_TS_ENTRY;
            ent_rec.id_a     = full[47:32];
            ent_rec.id_b     = full[31:16];
            skip_left_nxt    = {full[11:8], full[7:0]};
          end
          default: begin
            ent_rec.rec_kind              = REC_SERVICE;
            ent_rec.id_a                  = full[39:24];
            ent_rec.eit_schedule          = full[17];
            ent_rec.eit_present_following = full[16];
            ent_rec.running_status        = full[15:13];
            ent_rec.scrambled             = full[12];
            skip_left_nxt                 = {full[11:8], full[7:0]};
          end
        endcase
        entry_phase_nxt = '0;
        held_nxt        = '0;
      end else begin
        entry_phase_nxt = phase_inc;
        held_nxt        = full[39:0];
      end
      byte_pos_nxt = pos_s + 12'd1;
    end

    // Closing record: a partial header or entry, a pending skip or a short payload all
    // count as truncation.
    end_vld = in_ch.last_byte;
    if (err_s != ST_OK) begin
      st = err_s;
    end else if (kind_s == KIND_NONE) begin
      st = ST_UNSUPPORTED;
    end else if (byte_pos_nxt < in_ch.payload_len || byte_pos_nxt < hl ||
                 entry_phase_nxt != 3'd0 || skip_left_nxt != 12'd0) begin
      st = ST_TRUNCATED;
    end else begin
      st = ST_OK;
    end
    end_rec          = '0;
    end_rec.rec_kind = REC_END;
    end_rec.id_a     = in_ch.table_ext;
    end_rec.status   = st;
    end_rec.last     = 1'b1;

    if (in_ch.last_byte) begin
      kind_nxt        = KIND_NONE;
      err_nxt         = ST_OK;
      byte_pos_nxt    = '0;
      skip_left_nxt   = '0;
      entry_phase_nxt = '0;
      held_nxt        = '0;
    end
  end

  // Queue update: shift out the record taken, then append up to two new ones behind the
  // records that remain. The entry record always precedes the closing record.
  always_comb begin
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] n_push;
    rec_t             slot0;

    base   = cnt_r - CNT_W'(pop);
    n_push = accept ? (CNT_W'(ent_vld) + CNT_W'(end_vld)) : '0;
    slot0  = ent_vld ? ent_rec : end_rec;

    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (n_push != '0 && CNT_W'(i) == base) begin
        q_nxt[i] = slot0;
      end
      if (n_push == CNT_W'(2) && CNT_W'(i) == base + CNT_W'(1)) begin
        q_nxt[i] = end_rec;
      end
    end
    cnt_nxt = base + n_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r    <= '0;
      skip_left_r   <= '0;
      entry_phase_r <= '0;
      held_r        <= '0;
      kind_r        <= KIND_NONE;
      err_r         <= ST_OK;
      cnt_r         <= '0;
    end else begin
      if (accept) begin
        byte_pos_r    <= byte_pos_nxt;
        skip_left_r   <= skip_left_nxt;
        entry_phase_r <= entry_phase_nxt;
        held_r        <= held_nxt;
        kind_r        <= kind_nxt;
        err_r         <= err_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign in_ch.ready = (cnt_r <= CNT_W'(QDEPTH - 2));

  assign out_ch.valid                 = (cnt_r != '0);
  assign out_ch.rec_kind              = q_r[0].rec_kind;
  assign out_ch.id_a                  = q_r[0].id_a;
  assign out_ch.id_b                  = q_r[0].id_b;
  assign out_ch.eit_schedule          = q_r[0].eit_schedule;
  assign out_ch.eit_present_following = q_r[0].eit_present_following;
  assign out_ch.running_status        = q_r[0].running_status;
  assign out_ch.scrambled             = q_r[0].scrambled;
  assign out_ch.status                = q_r[0].status;
  assign out_ch.last                  = q_r[0].last;

`ifndef SYNTHESIS
  // The queue never holds more records than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QDEPTH))
    else $error("result queue overfilled");

  // A closed section leaves the parse state at its reset value.
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_byte) |=>
      (byte_pos_r == 12'd0 && skip_left_r == 12'd0 && entry_phase_r == 3'd0 &&
       kind_r == KIND_NONE && err_r == ST_OK))
    else $error("parse state not cleared after closing record");

  // The entry phase counter wraps before reaching the longest entry length.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    entry_phase_r < 3'd6)
    else $error("entry phase out of range");

  // Only the closing record carries last and a status.
  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.rec_kind != REC_END) |->
      (!out_ch.last && out_ch.status == ST_OK))
    else $error("entry record with closing fields");
`endif

endmodule

@@ verif/psi_section_payload_parser_tb.sv @@
// Self-checking testbench for psi_section_payload_parser: directed sections, then random ones.
// Every record is predicted beat by beat and checked in order as it leaves the block.
// Depends on pspp_pkg (codes, record layout) and pspp_if.sv (channel interfaces).
module psi_section_payload_parser_tb;
  import pspp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 2000;  // parsed or closing beats in the random part
  localparam int IDLE_PCT     = 13;    // chance of an idle cycle on either side
  localparam int QUIET_FROM   = 1000;  // stretch of the random part with no idling
  localparam int QUIET_TO     = 1400;
  localparam int HOLD_AT      = 700;   // input beats seen before the long receiver hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 1600;  // the sender waits for every record here
  localparam int DRAIN_CYCLES = 12;    // wait after the final drain for any stray record
  localparam int STALL_LIMIT  = 4000;  // cycles without any handshake before giving up
  localparam int NUM_DIRECTED = 27;

  // One payload byte with the section fields that travel alongside it.
  typedef struct packed {
    logic [7:0]  data;
    logic        first_mark;
    logic        last_mark;
    logic [7:0]  tid;
    logic [15:0] ext;
    logic [11:0] plen;
  } payload_beat_t;

  localparam int BEAT_W = $bits(payload_beat_t);

  // A directed step. Where typed is set, the closing record's status is written here by hand
  // rather than taken from the parser model below.
  typedef struct {
    logic [7:0]  data;
    logic        first_mark;
    logic        last_mark;
    logic [7:0]  tid;
    logic [15:0] ext;
    logic [11:0] plen;
    logic        typed;
    end_status_t st;
  } step_row_t;

  step_row_t dir_rows [NUM_DIRECTED] = '{
    // A lone closing mark straight after reset, outside any section.
    '{8'h00, 1'b0, 1'b1, 8'hFF,   16'h1234, 12'd0,   1'b1, ST_UNSUPPORTED},
    // Unsupported table, opened and closed on one beat, the side fields at their top values.
    '{8'hA5, 1'b1, 1'b1, 8'hFF,   16'hFFFF, 12'hFFF, 1'b1, ST_UNSUPPORTED},
    // PAT whose payload length is not a whole number of entries.
    '{8'h5A, 1'b1, 1'b1, TID_PAT, 16'h0000, 12'd5,   1'b1, ST_BAD_PAT_LEN},
    // PAT with a single network PID entry, the PID at its largest.
    '{8'h00, 1'b1, 1'b0, TID_PAT, 16'h0001, 12'd4,   1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, TID_PAT, 16'h0001, 12'd4,   1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, TID_PAT, 16'h0001, 12'd4,   1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b1, TID_PAT, 16'h0001, 12'd4,   1'b1, ST_OK},
    // PMT: PCR PID with reserved bits set, no programme descriptors, one stream.
    '{8'hFF, 1'b1, 1'b0, TID_PMT, 16'hFFFF, 12'd9,   1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, TID_PMT, 16'hFFFF, 12'd9,   1'b0, ST_OK},
    '{8'hF0, 1'b0, 1'b0, TID_PMT, 16'hFFFF, 12'd9,   1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, TID_PMT, 16'hFFFF, 12'd9,   1'b0, ST_OK},
    '{8'h1B, 1'b0, 1'b0, TID_PMT, 16'hFFFF, 12'd9,   1'b0, ST_OK},
    '{8'hE1, 1'b0, 1'b0, TID_PMT, 16'hFFFF, 12'd9,   1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, TID_PMT, 16'hFFFF, 12'd9,   1'b0, ST_OK},
    '{8'hF0, 1'b0, 1'b0, TID_PMT, 16'hFFFF, 12'd9,   1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b1, TID_PMT, 16'hFFFF, 12'd9,   1'b1, ST_OK},
    // NIT whose descriptor length plus the loop length overflows twelve bits.
    '{8'hFF, 1'b1, 1'b0, TID_NIT, 16'h8000, 12'd3,   1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, TID_NIT, 16'h8000, 12'd3,   1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b1, TID_NIT, 16'h8000, 12'd3,   1'b1, ST_TRUNCATED},
    // SDT: header, then one service with both EIT flags set and running status five.
    '{8'h7F, 1'b1, 1'b0, TID_SDT, 16'h0042, 12'd8,   1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, TID_SDT, 16'h0042, 12'd8,   1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, TID_SDT, 16'h0042, 12'd8,   1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, TID_SDT, 16'h0042, 12'd8,   1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, TID_SDT, 16'h0042, 12'd8,   1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, TID_SDT, 16'h0042, 12'd8,   1'b0, ST_OK},
    '{8'hA0, 1'b0, 1'b0, TID_SDT, 16'h0042, 12'd8,   1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b1, TID_SDT, 16'h0042, 12'd8,   1'b1, ST_OK}
  };

  logic clk = 1'b0;
  logic rst_n;

  pspp_in_if  in_ch ();
  pspp_out_if out_ch ();

  psi_section_payload_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Parse state of the model, kept at the same widths as in the block.
  logic [11:0] pos_q;
  logic [11:0] skip_q;
  logic [2:0]  phase_q;
  logic [39:0] held_q;
  tbl_kind_t   kind_q;
  end_status_t err_q;

  rec_t          exp_recs [$];   // records still to leave the block, oldest first
  payload_beat_t sec [$];        // beats of the random section being built
  logic [7:0]    body_bytes [$]; // payload bytes of that section

  int  errors     = 0;
  int  beats_in   = 0;  // every accepted input beat
  int  beats_used = 0;  // accepted beats that were parsed or closed a section
  int  recs_out   = 0;
  int  stall_cnt  = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  held_off   = 1'b0;

  function automatic void clear_parse();
    pos_q   = '0;
    skip_q  = '0;
    phase_q = '0;
    held_q  = '0;
    kind_q  = KIND_NONE;
    err_q   = ST_OK;
  endfunction

  function automatic int unsigned head_bytes(tbl_kind_t k);
    case (k)
      KIND_PMT: return 4;
      KIND_NIT: return 2;
      KIND_SDT: return 3;
      default:  return 0;
    endcase
  endfunction

  function automatic int unsigned entry_bytes(tbl_kind_t k);
    case (k)
      KIND_PAT: return 4;
      KIND_NIT: return 6;
      default:  return 5;
    endcase
  endfunction

  function automatic rec_t mk_rec(rec_kind_t k, logic [15:0] a, logic [15:0] b);
    rec_t r;
    r          = '0;
    r.rec_kind = k;
    r.id_a     = a;
    r.id_b     = b;
    return r;
  endfunction

  // Appends a record to the tail of the expected queue.
  function automatic void add_exp(rec_t r);
    exp_recs = {exp_recs, r};
  endfunction

  // Appends one payload byte to the section being built.
  function automatic void add_byte(logic [7:0] b);
    body_bytes = {body_bytes, b};
  endfunction

  // Advances the model by one accepted beat and queues the records it gives rise to.
  // The header or entry bytes are left-aligned in a 48-bit word, so the first byte of the
  // fixed part always sits in bits 47:40 whatever its length.
  // Returns 1 when the beat was parsed or closed a section, i.e. was not simply ignored.
  function automatic bit predict_beat(payload_beat_t bt, bit typed, end_status_t typed_st);
    int unsigned hl;
    int unsigned el;
    logic [47:0] w;
    logic [47:0] al;
    logic [12:0] nit_skip;
    rec_t        r;
    end_status_t st;
    bit          used;
    used = bt.last_mark;
    if (bt.first_mark) begin
      clear_parse();
      case (bt.tid)
        TID_PAT: kind_q = KIND_PAT;
        TID_PMT: kind_q = KIND_PMT;
        TID_NIT: kind_q = KIND_NIT;
        TID_SDT: kind_q = KIND_SDT;
        default: kind_q = KIND_NONE;
      endcase
      if (kind_q == KIND_NONE) err_q = ST_UNSUPPORTED;
      else if (kind_q == KIND_PAT && bt.plen[1:0] != 2'b00) err_q = ST_BAD_PAT_LEN;
    end

    if (kind_q != KIND_NONE && err_q == ST_OK && pos_q < bt.plen) begin
      used = 1'b1;
      hl   = head_bytes(kind_q);
      el   = entry_bytes(kind_q);
      w    = {held_q, bt.data};
      if (pos_q < hl) begin
        if (pos_q == hl - 1) begin
          al = w << (8 * (6 - hl));
          case (kind_q)
            KIND_PMT: begin
              add_exp(mk_rec(REC_PCR, bt.ext, {3'b000, al[44:40], al[39:32]}));
              skip_q = {al[27:24], al[23:16]};
            end
            KIND_NIT: begin
              // The two bytes of the transport stream loop length are skipped as well.
              nit_skip = {1'b0, al[43:40], al[39:32]} + 13'd2;
              skip_q   = nit_skip > 13'd4095 ? 12'hFFF : nit_skip[11:0];
            end
            default: add_exp(mk_rec(REC_ONID, bt.ext, al[47:32]));
          endcase
          held_q = '0;
        end else begin
          held_q = w[39:0];
        end
      end else if (skip_q != 0) begin
        skip_q = skip_q - 1'b1;
      end else begin
        phase_q = phase_q + 1'b1;
        if (phase_q >= el) begin
          al = w << (8 * (6 - el));
          case (kind_q)
            KIND_PAT: begin
              add_exp(mk_rec(al[47:32] == 16'h0000 ? REC_NET_PID : REC_PROG_PID,
                             al[47:32], {3'b000, al[28:24], al[23:16]}));
            end
            KIND_PMT: begin
              add_exp(mk_rec(REC_STREAM, {8'h00, al[47:40]},
                             {3'b000, al[36:32], al[31:24]}));
              skip_q = {al[19:16], al[15:8]};
            end
            KIND_NIT: begin
              add_exp(mk_rec(REC_TS_ENTRY, al[47:32], al[31:16]));
              skip_q = {al[11:8], al[7:0]};
            end
            default: begin
              r                       = mk_rec(REC_SERVICE, al[47:32], 16'h0000);
              r.eit_schedule          = al[25];
              r.eit_present_following = al[24];
              r.running_status        = al[23:21];
              r.scrambled             = al[20];
              add_exp(r);
              skip_q = {al[19:16], al[15:8]};
            end
          endcase
          phase_q = '0;
          held_q  = '0;
        end else begin
          held_q = w[39:0];
        end
      end
      pos_q = pos_q + 1'b1;
    end

    if (bt.last_mark) begin
      if (err_q != ST_OK) st = err_q;
      else if (kind_q == KIND_NONE) st = ST_UNSUPPORTED;
      else if (pos_q < bt.plen || pos_q < head_bytes(kind_q) || phase_q != 0 || skip_q != 0)
        st = ST_TRUNCATED;
      else st = ST_OK;
      r        = mk_rec(REC_END, bt.ext, 16'h0000);
      r.status = typed ? typed_st : st;
      r.last   = 1'b1;
      add_exp(r);
      clear_parse();
    end
    return used;
  endfunction

  // Offers one beat, with random idle cycles ahead of it, and holds it until it is taken.
  // valid is only ever written once per clock edge: either lowered for a gap or raised.
  task automatic send_beat(payload_beat_t bt, bit typed, end_status_t typed_st);
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= bt.data;
    in_ch.first_byte  <= bt.first_mark;
    in_ch.last_byte   <= bt.last_mark;
    in_ch.tbl_id      <= bt.tid;
    in_ch.table_ext   <= bt.ext;
    in_ch.payload_len <= bt.plen;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_beat(bt, typed, typed_st)) beats_used++;
    beats_in++;
  endtask

  // Stops offering beats and waits until every predicted record has left the block.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (exp_recs.size() != 0);
  endtask

  task automatic add_rand(int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  // A descriptor loop: a 12-bit length field with random upper bits, then that many bytes.
  // Now and then the high nibble of the length is random too, so that a long skip is still
  // pending when the section closes.
  task automatic add_desc();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
    add_byte({4'($urandom), ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0});
    add_byte(8'(n));
    add_rand(n);
  endtask

  // Builds one random section into sec. Most sections are well formed with random contents;
  // the rest carry extra bytes, are cut short, carry a random payload length, have their side
  // fields changed mid-section, lose their closing mark, or are stray bytes outside any section.
  task automatic build_section();
    logic [7:0]    tid;
    logic [15:0]   ext;
    logic [11:0]   plen;
    int            pick;
    int            variant;
    int            cut;
    payload_beat_t bt;
    body_bytes.delete();
    sec.delete();
    variant = $urandom_range(0, 99);

    if (variant >= 97) begin
      repeat ($urandom_range(1, 4)) begin
        bt            = BEAT_W'({$urandom, $urandom});
        bt.first_mark = 1'b0;
        bt.last_mark  = ($urandom_range(0, 2) == 0);
        sec           = {sec, bt};
      end
    end else begin
      pick = $urandom_range(0, 19);
      ext  = 16'($urandom);
      if (pick < 4) tid = TID_PAT;
      else if (pick < 9) tid = TID_PMT;
      else if (pick < 13) tid = TID_NIT;
      else if (pick < 18) tid = TID_SDT;
      else tid = 8'($urandom);

      case (tid)
        TID_PAT: begin
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
              add_byte(8'h00);
              add_byte(8'h00);
              add_rand(2);
            end else begin
              add_rand(4);
            end
          end
        end
        TID_PMT: begin
          add_rand(2);
          add_desc();
          repeat ($urandom_range(0, 3)) begin
            add_rand(3);
            add_desc();
          end
        end
        TID_NIT: begin
          add_desc();
          add_rand(2);
          repeat ($urandom_range(0, 3)) begin
            add_rand(4);
            add_desc();
          end
        end
        TID_SDT: begin
          add_rand(3);
          repeat ($urandom_range(0, 3)) begin
            add_rand(3);
            add_desc();
          end
        end
        default: add_rand($urandom_range(1, 6));
      endcase

      plen = 12'(body_bytes.size());
      // An empty payload still needs one beat to carry the marks; that byte is ignored.
      if (body_bytes.size() == 0) add_rand(1);

      if (variant < 8) begin
        add_rand($urandom_range(1, 3));
      end else if (variant >= 72 && variant < 80) begin
        cut = $urandom_range(1, body_bytes.size());
        while (body_bytes.size() > cut) void'(body_bytes.pop_back());
      end else if (variant >= 80 && variant < 87) begin
        plen = 12'($urandom);
      end

      foreach (body_bytes[i]) begin
        bt.data       = body_bytes[i];
        bt.first_mark = (i == 0);
        bt.last_mark  = (i == body_bytes.size() - 1) && !(variant >= 93);
        bt.tid        = tid;
        bt.ext        = ext;
        bt.plen       = plen;
        if (variant >= 87 && variant < 93 && i > 0) begin
          bt.tid = 8'($urandom);
          bt.ext = 16'($urandom);
        end
        sec = {sec, bt};
      end
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: record %0d field %s expected %0h actual %0h",
               $time, recs_out, name, want, got);
      errors++;
    end
  endtask

  // Output monitor: every accepted record is compared with the oldest one predicted.
  always @(posedge clk) begin
    rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_recs.size() == 0) begin
        $display("%0t: record %0d expected none actual kind %0d id_a %0h id_b %0h",
                 $time, recs_out, out_ch.rec_kind, out_ch.id_a, out_ch.id_b);
        errors++;
      end else begin
        want = exp_recs.pop_front();
        check_field("rec_kind", want.rec_kind, out_ch.rec_kind);
        check_field("id_a", want.id_a, out_ch.id_a);
        check_field("id_b", want.id_b, out_ch.id_b);
        check_field("eit_schedule", want.eit_schedule, out_ch.eit_schedule);
        check_field("eit_present_following", want.eit_present_following,
                    out_ch.eit_present_following);
        check_field("running_status", want.running_status, out_ch.running_status);
        check_field("scrambled", want.scrambled, out_ch.scrambled);
        check_field("status", want.status, out_ch.status);
        check_field("last", want.last, out_ch.last);
      end
      recs_out++;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off in the random part so that the
  // result queue fills and the block has to stall its input while the sender keeps offering.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !held_off && beats_in >= HOLD_AT) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= rst_n && !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog: a run that stops moving in both directions for too long has hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Stimulus: reset, the directed table, then random sections until enough beats were used.
  initial begin
    payload_beat_t bt;
    bit            paused;
    paused = 1'b0;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.data_byte       <= '0;
    in_ch.first_byte      <= 1'b0;
    in_ch.last_byte       <= 1'b0;
    in_ch.tbl_id          <= '0;
    in_ch.table_ext       <= '0;
    in_ch.payload_len     <= '0;
    clear_parse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      bt = '{dir_rows[i].data, dir_rows[i].first_mark, dir_rows[i].last_mark,
             dir_rows[i].tid, dir_rows[i].ext, dir_rows[i].plen};
      send_beat(bt, dir_rows[i].typed, dir_rows[i].st);
    end
    drain_results();

    beats_used = 0;
    while (beats_used < RANDOM_BEATS) begin
      // A quiet stretch in the middle with both sides running flat out.
      tx_idle_on = !(beats_used >= QUIET_FROM && beats_used < QUIET_TO);
      rx_idle_on = tx_idle_on;
      if (!paused && beats_used >= PAUSE_AT) begin
        paused = 1'b1;
        drain_results();
      end
      build_section();
      foreach (sec[i]) send_beat(sec[i], 1'b0, ST_OK);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
